### rtl/core/sst_pkg.sv
// ============================================================================
// sst_pkg
// Shared types, codes and the control store of the session token table.
// ============================================================================
package sst_pkg;

  // Default table depth and register reset
  localparam int unsigned SLOTS_DEF   = 6;
  localparam int unsigned TTL_W       = 48;
  localparam int unsigned TIME_W      = 62;
  localparam int unsigned TOKEN_W     = 64;
  localparam logic [TTL_W-1:0] TTL_RESET = 48'd604800000000;  // seven days in us

  // Request function codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_CHECK  = 2'd1;
  localparam logic [1:0] FUNC_KILL   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Program counter addresses
  localparam int unsigned PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE      = 3'd0;
  localparam logic [PC_W-1:0] PC_CRT_SCAN  = 3'd1;
  localparam logic [PC_W-1:0] PC_CRT_WRITE = 3'd2;
  localparam logic [PC_W-1:0] PC_CHK_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] PC_CHK_DONE  = 3'd4;
  localparam logic [PC_W-1:0] PC_KILL_SCAN = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT_CNT  = 3'd6;
  localparam logic [PC_W-1:0] PC_CLR_SCAN  = 3'd7;

  // Datapath actions
  localparam logic [2:0] ACT_IDLE      = 3'd0;
  localparam logic [2:0] ACT_CRT_SCAN  = 3'd1;
  localparam logic [2:0] ACT_CRT_WRITE = 3'd2;
  localparam logic [2:0] ACT_CHK_SCAN  = 3'd3;
  localparam logic [2:0] ACT_CHK_DONE  = 3'd4;
  localparam logic [2:0] ACT_KILL_SCAN = 3'd5;
  localparam logic [2:0] ACT_EMIT_CNT  = 3'd6;
  localparam logic [2:0] ACT_CLR_SCAN  = 3'd7;

  // Sequencing conditions
  localparam logic [1:0] COND_START = 2'd0;  // wait for start, then dispatch on func
  localparam logic [1:0] COND_SCAN  = 2'd1;  // step slots until hit or last slot
  localparam logic [1:0] COND_GOTO  = 2'd2;  // unconditional jump

  // One control word
  typedef struct packed {
    logic [2:0]      act;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic       accept;
    logic       idx_inc;
    logic [2:0] act;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic hit;
    logic last;
  } status_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:      w = '{act: ACT_IDLE,      cond: COND_START, target: PC_IDLE};
      PC_CRT_SCAN:  w = '{act: ACT_CRT_SCAN,  cond: COND_SCAN,  target: PC_CRT_WRITE};
      PC_CRT_WRITE: w = '{act: ACT_CRT_WRITE, cond: COND_GOTO,  target: PC_IDLE};
      PC_CHK_SCAN:  w = '{act: ACT_CHK_SCAN,  cond: COND_SCAN,  target: PC_CHK_DONE};
      PC_CHK_DONE:  w = '{act: ACT_CHK_DONE,  cond: COND_GOTO,  target: PC_IDLE};
      PC_KILL_SCAN: w = '{act: ACT_KILL_SCAN, cond: COND_SCAN,  target: PC_EMIT_CNT};
      PC_EMIT_CNT:  w = '{act: ACT_EMIT_CNT,  cond: COND_GOTO,  target: PC_IDLE};
      PC_CLR_SCAN:  w = '{act: ACT_CLR_SCAN,  cond: COND_SCAN,  target: PC_EMIT_CNT};
      default:      w = '{act: ACT_IDLE,      cond: COND_GOTO,  target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each request's routine
  function automatic logic [PC_W-1:0] func_entry(input logic [1:0] func);
    logic [PC_W-1:0] pc;
    unique case (func)
      FUNC_CREATE: pc = PC_CRT_SCAN;
      FUNC_CHECK:  pc = PC_CHK_SCAN;
      FUNC_KILL:   pc = PC_KILL_SCAN;
      FUNC_CLEAR:  pc = PC_CLR_SCAN;
      default:     pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

### rtl/core/sst_useq.sv
// ============================================================================
// sst_useq
// Microcode sequencer: program counter, control store lookup and jumps.
// ============================================================================
module sst_useq import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  status_t    status_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  logic [PC_W-1:0] pc_d, pc_q;
  ucode_t          uw;

  assign uw     = ucode_rom(pc_q);
  assign busy_o = (pc_q != PC_IDLE);

  // Decode the control word and pick the next step
  always_comb begin
    pc_d           = pc_q;
    ctrl_o.act     = uw.act;
    ctrl_o.accept  = 1'b0;
    ctrl_o.idx_inc = 1'b0;
    unique case (uw.cond)
      COND_START: begin
        if (start_i) begin
          ctrl_o.accept = 1'b1;
          pc_d          = func_entry(func_i);
        end
      end
      COND_SCAN: begin
        if (status_i.hit || status_i.last) begin
          pc_d = uw.target;
        end else begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      COND_GOTO: begin
        pc_d = uw.target;
      end
      default: begin
        pc_d = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/core/sst_dpath.sv
// ============================================================================
// sst_dpath
// Datapath: entry memory, valid bits, slot index, compare and result logic.
// ============================================================================
module sst_dpath import sst_pkg::*; #(
  parameter int unsigned Slots = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output status_t            status_o,
  input  logic               ttl_we_i,
  input  logic [TTL_W-1:0]   ttl_us_i,
  input  logic [TIME_W-1:0]  now_us_i,
  input  logic [TOKEN_W-1:0] token_hi_i,
  input  logic [TOKEN_W-1:0] token_lo_i,
  input  logic               token_given_i,
  output logic               done_o,
  output logic               granted_o,
  output logic [2:0]         slot_o,
  output logic [2:0]         removed_o
);

  localparam int unsigned IdxW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned EntryW = 2 * TOKEN_W + TIME_W;

  // Entry memory: token high, token low, expiry
  logic [EntryW-1:0] mem [Slots];
  logic [EntryW-1:0] rd_q;
  logic              wr_en;

  logic [Slots-1:0]   valid_d, valid_q;
  logic [IdxW-1:0]    idx_d, idx_q;
  logic [IdxW-1:0]    pick_d, pick_q;
  logic [TIME_W-1:0]  oldest_d, oldest_q;
  logic               found_d, found_q;
  logic [2:0]         cnt_d, cnt_q;
  logic [TTL_W-1:0]   ttl_q;

  logic [TIME_W-1:0]  now_q;
  logic [TOKEN_W-1:0] hi_q, lo_q;
  logic               given_q;

  logic               done_d, done_q;
  logic               granted_d, granted_q;
  logic [2:0]         slot_d, slot_q;
  logic [2:0]         removed_d, removed_q;

  logic [TOKEN_W-1:0] rd_hi, rd_lo;
  logic [TIME_W-1:0]  rd_exp;
  logic               cur_valid, tok_eq, free, live;
  logic               scan_hit, scan_last;
  logic [TIME_W:0]    exp_sum;
  logic [TIME_W-1:0]  exp_sat;
  logic [IdxW+2:0]    pick_ext;

  assign rd_hi  = rd_q[EntryW-1 -: TOKEN_W];
  assign rd_lo  = rd_q[TIME_W +: TOKEN_W];
  assign rd_exp = rd_q[TIME_W-1:0];

  // Compare the current slot against the request
  assign cur_valid = valid_q[idx_q];
  assign tok_eq    = given_q && cur_valid && (rd_hi == hi_q) && (rd_lo == lo_q);
  assign free      = !cur_valid || (rd_exp < now_q);
  assign live      = rd_exp > now_q;

  // Saturate the new expiry at the top of the time range
  assign exp_sum = {1'b0, now_q} + {{(TIME_W + 1 - TTL_W){1'b0}}, ttl_q};
  assign exp_sat = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

  // Slot number wraps to three bits
  assign pick_ext = {3'b000, pick_q};

  assign scan_last = (idx_q == IdxW'(Slots - 1));
  assign status_o  = '{hit: scan_hit, last: scan_last};
  assign wr_en     = (ctrl_i.act == ACT_CRT_WRITE);

  // Reset the scan index on transfer and advance it while scanning
  always_comb begin
    if (ctrl_i.accept) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  // Execute the current action
  always_comb begin
    valid_d   = valid_q;
    pick_d    = pick_q;
    oldest_d  = oldest_q;
    found_d   = found_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    slot_d    = slot_q;
    removed_d = removed_q;
    scan_hit  = 1'b0;
    if (ctrl_i.accept) begin
      pick_d   = '0;
      oldest_d = {TIME_W{1'b1}};
      found_d  = 1'b0;
      cnt_d    = '0;
    end
    unique case (ctrl_i.act)
      ACT_IDLE: begin
      end
      ACT_CRT_SCAN: begin
        scan_hit = free;
        if (free) begin
          pick_d = idx_q;
        end else if (rd_exp < oldest_q) begin
          pick_d   = idx_q;
          oldest_d = rd_exp;
        end
      end
      ACT_CRT_WRITE: begin
        valid_d[pick_q] = 1'b1;
        done_d          = 1'b1;
        granted_d       = 1'b1;
        slot_d          = pick_ext[2:0];
        removed_d       = '0;
      end
      ACT_CHK_SCAN: begin
        scan_hit = tok_eq && live;
        if (tok_eq && live) begin
          found_d = 1'b1;
          pick_d  = idx_q;
        end
      end
      ACT_CHK_DONE: begin
        done_d    = 1'b1;
        granted_d = found_q;
        slot_d    = found_q ? pick_ext[2:0] : 3'b000;
        removed_d = '0;
      end
      ACT_KILL_SCAN: begin
        if (tok_eq) begin
          valid_d[idx_q] = 1'b0;
          cnt_d          = cnt_q + 3'd1;
        end
      end
      ACT_CLR_SCAN: begin
        if (cur_valid) begin
          valid_d[idx_q] = 1'b0;
          cnt_d          = cnt_q + 3'd1;
        end
      end
      ACT_EMIT_CNT: begin
        done_d    = 1'b1;
        granted_d = 1'b0;
        slot_d    = '0;
        removed_d = cnt_q;
      end
      default: begin
      end
    endcase
  end

  // Write the new entry and read the slot under scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pick_q] <= {hi_q, lo_q, exp_sat};
    end
    rd_q <= mem[idx_d];
  end

  // Capture the request operands on transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      now_q   <= now_us_i;
      hi_q    <= token_hi_i;
      lo_q    <= token_lo_i;
      given_q <= token_given_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      idx_q     <= '0;
      pick_q    <= '0;
      oldest_q  <= '0;
      found_q   <= 1'b0;
      cnt_q     <= '0;
      ttl_q     <= TTL_RESET;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
      slot_q    <= '0;
      removed_q <= '0;
    end else begin
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      pick_q    <= pick_d;
      oldest_q  <= oldest_d;
      found_q   <= found_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      granted_q <= granted_d;
      slot_q    <= slot_d;
      removed_q <= removed_d;
      if (ttl_we_i) begin
        ttl_q <= ttl_us_i;
      end
    end
  end

  assign done_o    = done_q;
  assign granted_o = granted_q;
  assign slot_o    = slot_q;
  assign removed_o = removed_q;

endmodule

### rtl/core/session_token_table.sv
// ============================================================================
// session_token_table
// Table of session tokens with expiry: create, check, kill and clear all.
// ============================================================================
// Timing: after the transfer the routine scans k slots (1..Slots, one
// slot per cycle through the entry memory read port), then runs its final
// step; done_o is registered and rises in the cycle after that step.
// Requests: one at a time; a new transfer is taken only when idle.
// Reset: all entries invalid, ttl_us back to seven days; results cannot stall.
module session_token_table import sst_pkg::*; #(
  parameter int unsigned Slots = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [TIME_W-1:0]  now_us_i,
  input  logic [TOKEN_W-1:0] token_hi_i,
  input  logic [TOKEN_W-1:0] token_lo_i,
  input  logic               token_given_i,
  input  logic               ttl_we_i,
  input  logic [TTL_W-1:0]   ttl_us_i,
  output logic               done_o,
  output logic               granted_o,
  output logic [2:0]         slot_o,
  output logic [2:0]         removed_o
);

  ctrl_t   ctrl;
  status_t status;

  sst_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o)
  );

  sst_dpath #(
    .Slots (Slots)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .ttl_we_i      (ttl_we_i),
    .ttl_us_i      (ttl_us_i),
    .now_us_i      (now_us_i),
    .token_hi_i    (token_hi_i),
    .token_lo_i    (token_lo_i),
    .token_given_i (token_given_i),
    .done_o        (done_o),
    .granted_o     (granted_o),
    .slot_o        (slot_o),
    .removed_o     (removed_o)
  );

  // A result only follows a request in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a request in progress");

  // A transfer always starts a routine
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer did not start a routine");

  // Granted results never report removed entries
  a_grant_no_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_o) |-> (removed_o == 3'd0))
    else $error("granted result with removed count");

endmodule
